>>> hdl/klcp_pkg.sv
// Shared types and constants for the keyboard line command parser.
// Holds the result event codes, the character codes and the key-code lookup.
// No dependencies.
package klcp_pkg;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_KEY_UP,
    EV_PUSH,
    EV_DUP,
    EV_UNMAPPED,
    EV_IGNORED,
    EV_OVERLONG
  } ev_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_K     = 8'h4b;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_D     = 8'h44;

  localparam int OUT_BITS = 192;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_term(logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
  endfunction

  // Key code to matrix code; zero means the code has no matrix position.
  function automatic logic [6:0] raw_of_code(logic [7:0] code);
    logic [6:0] raw;
    raw = 7'h00;
    case (code) inside
      8'h3b: raw = 7'h33;
      8'h3c: raw = 7'h37;
      8'h3d: raw = 7'h3c;
      [8'h3e:8'h44]: raw = code[6:0];
      8'h45: raw = 7'h35;
      8'h46: raw = 7'h36;
      8'h47: raw = 7'h3b;
      [8'h48:8'h4c]: raw = code[6:0];
      8'h4d: raw = 7'h3d;
      8'h4e: raw = 7'h62;
      [8'h54:8'h61]: raw = code[6:0];
      8'h62: raw = 7'h34;
      [8'h63:8'h67]: raw = code[6:0];
      8'h68: raw = 7'h72;
      8'h69: raw = 7'h7f;
      8'h6a: raw = 7'h7e;
      8'h6b: raw = 7'h7d;
      8'h6c: raw = 7'h7c;
      8'h6d: raw = 7'h77;
      8'h6e: raw = 7'h76;
      8'h6f: raw = 7'h75;
      8'h70: raw = 7'h74;
      8'h71: raw = 7'h73;
      8'h72: raw = 7'h68;
      8'h73: raw = 7'h71;
      8'h74: raw = 7'h70;
      8'h75: raw = 7'h6f;
      8'h76: raw = 7'h6e;
      8'h77: raw = 7'h6d;
      8'h78: raw = 7'h2b;
      8'h79: raw = 7'h2c;
      8'h7a: raw = 7'h2d;
      8'h7b: raw = 7'h2e;
      8'h7c: raw = 7'h6c;
      8'h7d: raw = 7'h6b;
      8'h7e: raw = 7'h6a;
      8'h7f: raw = 7'h69;
      default: raw = 7'h00;
    endcase
    return raw;
  endfunction

endpackage

>>> hdl/keyboard_line_command_parser_unit.sv
// Keyboard line command parser, depends on klcp_pkg. A byte that is stored or dropped gives
// its result in the cycle after the input transfer; a terminator ending a stored line walks
// the store (trims, then the command a byte a cycle) before its result is registered.
// One byte is in work at a time; the next is taken once the parser is idle and the result
// register is empty or is being drained.
// Asynchronous active-low reset clears all but the line store and its read register.
module keyboard_line_command_parser_unit #(
  parameter int LINE_BYTES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // rx_byte[7:0]
  input  logic [7:0]                      s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // event_res[2:0], key_push[3], raw_key[10:4], key_held[11], held_code[27:12],
  // lines_count[59:28], key_up_count[91:60], key_down_count[123:92],
  // duplicate_count[155:124], unmapped_count[187:156], zero padding[191:188]
  output logic [klcp_pkg::OUT_BITS-1:0]   m_axis_tdata_o
);

  localparam int LEN_W = $clog2(LINE_BYTES);
  localparam int DEPTH = LINE_BYTES - 1;
  localparam logic [LEN_W-1:0] LAST_IDX = LEN_W'(LINE_BYTES - 1);
  localparam logic [LEN_W-1:0] ONE      = LEN_W'(1);
  localparam logic [LEN_W-1:0] TWO      = LEN_W'(2);
  localparam logic [LEN_W-1:0] THREE    = LEN_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD,
    ST_K,
    ST_OP,
    ST_DIG,
    ST_KD
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             held_q, held_d;
  logic [15:0]      held_val_q, held_val_d;
  logic [31:0]      cnt_lines_q, cnt_lines_d;
  logic [31:0]      cnt_up_q, cnt_up_d;
  logic [31:0]      cnt_down_q, cnt_down_d;
  logic [31:0]      cnt_dup_q, cnt_dup_d;
  logic [31:0]      cnt_unm_q, cnt_unm_d;
  logic [LEN_W-1:0] s_q, s_d;
  logic [LEN_W-1:0] e_q, e_d;
  logic [LEN_W-1:0] ptr_q, ptr_d;
  logic [15:0]      value_q, value_d;
  klcp_pkg::ev_e    ev_q, ev_d;
  logic [6:0]       raw_q, raw_d;
  logic             out_valid_q, out_valid_d;

  logic [7:0]       store [DEPTH];
  logic [7:0]       rdata_q;
  logic             store_we;

  logic             in_xfer;
  logic [LEN_W-1:0] trim_len;
  logic [19:0]      mac;
  logic [6:0]       lookup;
  logic             ignore_line;
  logic             finish;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign trim_len        = e_q - s_q;

  // Decimal accumulate: value * 10 + digit, wide enough to see an overflow.
  assign mac    = ({4'b0, value_q} << 3) + ({4'b0, value_q} << 1) + {16'b0, rdata_q[3:0]};
  assign lookup = (value_q[15:8] == 8'h00) ? klcp_pkg::raw_of_code(value_q[7:0]) : 7'h00;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    held_d      = held_q;
    held_val_d  = held_val_q;
    cnt_lines_d = cnt_lines_q;
    cnt_up_d    = cnt_up_q;
    cnt_down_d  = cnt_down_q;
    cnt_dup_d   = cnt_dup_q;
    cnt_unm_d   = cnt_unm_q;
    s_d         = s_q;
    e_d         = e_q;
    ptr_d       = ptr_q;
    value_d     = value_q;
    ev_d        = ev_q;
    raw_d       = raw_q;
    out_valid_d = out_valid_q;
    store_we    = 1'b0;
    ignore_line = 1'b0;
    finish      = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          ev_d  = klcp_pkg::EV_NONE;
          raw_d = 7'h00;
          if (klcp_pkg::is_term(s_axis_tdata_i)) begin
            len_d = '0;
            ovf_d = 1'b0;
            if (ovf_q) begin
              cnt_unm_d   = cnt_unm_q + 32'd1;
              ev_d        = klcp_pkg::EV_OVERLONG;
              out_valid_d = 1'b1;
            end else if (len_q != '0) begin
              e_d     = len_q;
              ptr_d   = '0;
              state_d = ST_FWD;
            end else begin
              out_valid_d = 1'b1;
            end
          end else begin
            if (!ovf_q) begin
              if (len_q == LAST_IDX) begin
                ovf_d = 1'b1;
              end else begin
                store_we = 1'b1;
                len_d    = len_q + ONE;
              end
            end
            out_valid_d = 1'b1;
          end
        end
      end
      ST_FWD: begin
        if (klcp_pkg::is_blank(rdata_q)) begin
          if (ptr_q + ONE == e_q) begin
            // Blank line: nothing is counted.
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            ptr_d = ptr_q + ONE;
          end
        end else begin
          s_d     = ptr_q;
          ptr_d   = e_q - ONE;
          state_d = ST_BWD;
        end
      end
      ST_BWD: begin
        // The first non-blank byte stops this walk, so it never passes the start.
        if (klcp_pkg::is_blank(rdata_q)) begin
          ptr_d = ptr_q - ONE;
        end else begin
          e_d         = ptr_q + ONE;
          cnt_lines_d = cnt_lines_q + 32'd1;
          ptr_d       = s_q;
          state_d     = ST_K;
        end
      end
      ST_K: begin
        if (trim_len >= TWO && rdata_q == klcp_pkg::CH_K) begin
          ptr_d   = s_q + ONE;
          state_d = ST_OP;
        end else begin
          ignore_line = 1'b1;
        end
      end
      ST_OP: begin
        if (rdata_q == klcp_pkg::CH_U && trim_len == TWO) begin
          cnt_up_d   = cnt_up_q + 32'd1;
          held_d     = 1'b0;
          held_val_d = 16'h0000;
          ev_d       = klcp_pkg::EV_KEY_UP;
          finish     = 1'b1;
        end else if (rdata_q == klcp_pkg::CH_D && trim_len >= THREE) begin
          ptr_d   = s_q + TWO;
          value_d = 16'h0000;
          state_d = ST_DIG;
        end else begin
          ignore_line = 1'b1;
        end
      end
      ST_DIG: begin
        if (!klcp_pkg::is_digit(rdata_q) || mac[19:16] != 4'h0) begin
          ignore_line = 1'b1;
        end else begin
          value_d = mac[15:0];
          if (ptr_q + ONE == e_q) begin
            state_d = ST_KD;
          end else begin
            ptr_d = ptr_q + ONE;
          end
        end
      end
      ST_KD: begin
        cnt_down_d = cnt_down_q + 32'd1;
        if (held_q && held_val_q == value_q) begin
          cnt_dup_d = cnt_dup_q + 32'd1;
          ev_d      = klcp_pkg::EV_DUP;
        end else begin
          held_d     = 1'b1;
          held_val_d = value_q;
          if (lookup != 7'h00) begin
            raw_d = lookup;
            ev_d  = klcp_pkg::EV_PUSH;
          end else begin
            cnt_unm_d = cnt_unm_q + 32'd1;
            ev_d      = klcp_pkg::EV_UNMAPPED;
          end
        end
        finish = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (ignore_line) begin
      cnt_unm_d = cnt_unm_q + 32'd1;
      ev_d      = klcp_pkg::EV_IGNORED;
      finish    = 1'b1;
    end
    if (finish) begin
      out_valid_d = 1'b1;
      state_d     = ST_IDLE;
    end
  end

  // Line store: one write port for incoming bytes, one registered read port for the walk.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store[len_q] <= s_axis_tdata_i;
    end
    if (ptr_d < LAST_IDX) begin
      rdata_q <= store[ptr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      held_q      <= 1'b0;
      held_val_q  <= 16'h0000;
      cnt_lines_q <= 32'd0;
      cnt_up_q    <= 32'd0;
      cnt_down_q  <= 32'd0;
      cnt_dup_q   <= 32'd0;
      cnt_unm_q   <= 32'd0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      s_q         <= '0;
      e_q         <= '0;
      value_q     <= 16'h0000;
      ev_q        <= klcp_pkg::EV_NONE;
      raw_q       <= 7'h00;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      held_q      <= held_d;
      held_val_q  <= held_val_d;
      cnt_lines_q <= cnt_lines_d;
      cnt_up_q    <= cnt_up_d;
      cnt_down_q  <= cnt_down_d;
      cnt_dup_q   <= cnt_dup_d;
      cnt_unm_q   <= cnt_unm_d;
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
      s_q         <= s_d;
      e_q         <= e_d;
      value_q     <= value_d;
      ev_q        <= ev_d;
      raw_q       <= raw_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, cnt_unm_q, cnt_dup_q, cnt_down_q, cnt_up_q, cnt_lines_q,
                            held_val_q, held_q, raw_q, (ev_q == klcp_pkg::EV_PUSH), ev_q};

endmodule
